// File: design/masked_byte_pattern_search_defines.svh
// Assertion helpers for the masked byte pattern search.
// Both sample on clk and are disabled while rst is high.
`ifndef MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH

// Same-cycle implication.
`define MBPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mbps_pkg.sv
`default_nettype none

package mbps_pkg;

  localparam int PAT_BYTES = 32;   // bytes the pattern registers hold
  localparam int LEN_W     = 6;
  localparam int ADDR_W    = 48;
  localparam int REG_IDX_W = 3;

  // register index, byte address is 8 * index
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CARE      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BASE      = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET    = 3'd7;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pattern;
    logic [PAT_BYTES-1:0]      care;
    logic [LEN_W-1:0]          len;
    logic [ADDR_W-1:0]         bias;   // base_address + sign-extended result_offset
  } cfg_t;

endpackage

`default_nettype wire

// File: design/mbps_regs.sv
`default_nettype none

module mbps_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  output mbps_pkg::cfg_t       cfg
);
  import mbps_pkg::*;

  logic [3:0][63:0]      pattern_word;
  logic [PAT_BYTES-1:0]  care_mask;
  logic [LEN_W-1:0]      pattern_length;
  logic [ADDR_W-1:0]     base_address;
  logic [31:0]           result_offset;
  logic [ADDR_W-1:0]     bias;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[5:3];

  // bias tracks base + offset so the result path needs only one add
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_word   <= '0;
      care_mask      <= '0;
      pattern_length <= '0;
      base_address   <= '0;
      result_offset  <= '0;
      bias           <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PATTERN_0: pattern_word[0] <= pwdata;
        REG_PATTERN_1: pattern_word[1] <= pwdata;
        REG_PATTERN_2: pattern_word[2] <= pwdata;
        REG_PATTERN_3: pattern_word[3] <= pwdata;
        REG_CARE:      care_mask <= pwdata[31:0];
        REG_LENGTH:    pattern_length <= pwdata[LEN_W-1:0];
        REG_BASE: begin
          base_address <= pwdata[ADDR_W-1:0];
          bias <= pwdata[ADDR_W-1:0] + {{16{result_offset[31]}}, result_offset};
        end
        REG_OFFSET: begin
          result_offset <= pwdata[31:0];
          bias <= base_address + {{16{pwdata[31]}}, pwdata[31:0]};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PATTERN_0: prdata = pattern_word[0];
      REG_PATTERN_1: prdata = pattern_word[1];
      REG_PATTERN_2: prdata = pattern_word[2];
      REG_PATTERN_3: prdata = pattern_word[3];
      REG_CARE:      prdata = {32'd0, care_mask};
      REG_LENGTH:    prdata = {58'd0, pattern_length};
      REG_BASE:      prdata = {16'd0, base_address};
      REG_OFFSET:    prdata = {32'd0, result_offset};
      default:       prdata = '0;
    endcase
  end

  // fields in struct order: pattern, care, len, bias
  assign cfg = {pattern_word, care_mask, pattern_length, bias};

endmodule

`default_nettype wire

// File: design/mbps_cell.sv
`default_nettype none

// One window slot: holds the byte IDX places back and checks it against
// the pattern byte that lines up with it for the current length.
module mbps_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           shift_en,
  input  logic [7:0]     din,
  input  mbps_pkg::cfg_t cfg,
  output logic [7:0]     dout,
  output logic           ok
);
  import mbps_pkg::*;

  localparam logic [6:0] SLOT = 7'(IDX);

  logic       active;
  logic [6:0] pat_idx;
  logic [4:0] sel;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      dout <= din;
    end
  end

  // slot IDX faces pattern byte len-1-IDX
  assign active  = {1'b0, cfg.len} > SLOT;
  assign pat_idx = {1'b0, cfg.len} - SLOT - 7'd1;
  assign sel     = pat_idx[4:0];
  assign ok      = !active || !cfg.care[sel] || (dout == cfg.pattern[sel]);

endmodule

`default_nettype wire

// File: design/masked_byte_pattern_search.sv
`default_nettype none

// Channel   Dir  Fields (low bit up)                     Beat
// s_axis    in   tdata: data_byte[7:0]; tlast: region_last one byte of the region
// m_axis    out  tdata: match_address[47:0]; tuser: found  one result per region
// apb       in   8 regs at 8*i, 64-bit data               one register write
//
// One byte per cycle sustained. An accepted byte shifts into the cell chain;
// stage 1 then compares the window and, on the last byte, loads the output
// register once the output is not stalled.
// Reset clears control state and configuration; the window is not reset.
// Input stalls only while a result sits in the output register unclaimed.
module masked_byte_pattern_search #(
  parameter int PATTERN_MAX   = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // data_byte[7:0]
  input  logic        s_axis_tlast,    // region_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,    // match_address[47:0]
  output logic        m_axis_tuser,    // found
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import mbps_pkg::*;

  localparam int         PW      = POSITION_BITS;
  localparam logic [6:0] MAX_LEN = 7'(PATTERN_MAX);

  cfg_t cfg;

  mbps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake
  logic accept;
  logic stall;
  logic fire;        // stage 1 item retires this edge
  logic end_region;

  // cell chain: slot 0 holds the newest byte
  logic [PATTERN_MAX-1:0][7:0] win;
  logic [PATTERN_MAX-1:0]      ok;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [7:0] din;
    if (k == 0) begin : g_head
      assign din = s_axis_tdata;
    end else begin : g_tail
      assign din = win[k-1];
    end
    mbps_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .shift_en (accept),
      .din      (din),
      .cfg      (cfg),
      .dout     (win[k]),
      .ok       (ok[k])
    );
  end

  // region position, saturating
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_base;
  logic [PW-1:0] pos_next;

  // stage 1: byte accepted, window ready to compare
  logic          s1_valid;
  logic          s1_last;
  logic          s1_ge;      // enough bytes for the pattern
  logic [PW-1:0] s1_cand;    // start position if this byte completes a match

  logic          seen;
  logic [PW-1:0] start;
  logic          len_ok;
  logic          hit;
  logic          found_now;
  logic [PW-1:0] start_sel;

  assign stall         = m_axis_tvalid && !m_axis_tready;
  assign s_axis_tready = !stall;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = s1_valid && !stall;
  assign end_region    = fire && s1_last;

  // a byte of the next region may enter as the last one retires
  assign pos_base = end_region ? '0 : pos;
  always_comb begin
    pos_next = pos_base;
    if (accept && (pos_base != {PW{1'b1}})) begin
      pos_next = pos_base + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
    end else begin
      pos      <= pos_next;
      s1_valid <= accept || (s1_valid && stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last <= s_axis_tlast;
      s1_ge   <= pos_next >= PW'(cfg.len);
      s1_cand <= pos_next - PW'(cfg.len);
    end
  end

  // compare: all active slots agree, enough bytes are in and the length is usable
  assign len_ok    = (cfg.len != '0) && ({1'b0, cfg.len} <= 7'(PAT_BYTES)) &&
                     ({1'b0, cfg.len} <= MAX_LEN);
  assign hit       = len_ok && s1_ge && (&ok);
  assign found_now = seen || hit;
  assign start_sel = seen ? start : s1_cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (end_region) begin
      seen <= 1'b0;
    end else if (fire && hit) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !seen && hit) begin
      start <= s1_cand;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (end_region) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_region) begin
      m_axis_tuser <= found_now;
      m_axis_tdata <= found_now ? (cfg.bias + ADDR_W'(start_sel)) : '0;
    end
  end

`include "masked_byte_pattern_search_defines.svh"

  `MBPS_ASSERT_NEXT(a_seen_clears, end_region, !seen, "match flag kept past region end")
  `MBPS_ASSERT_NEXT(a_pos_restarts, end_region && !accept, pos == '0, "position not restarted")
  `MBPS_ASSERT_NOW(a_out_source, $rose(m_axis_tvalid), $past(s1_valid && s1_last), "result without last byte")
  `MBPS_ASSERT_NOW(a_none_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "address set on miss")

endmodule

`default_nettype wire
